@@ sv/btnv_pkg.sv @@
// Shared types and constants for the BT.709 RGB / NV12 quad converter.
// No dependencies; every other file imports this package.
package btnv_pkg;

  localparam int NPIX = 4;          // pixels in one 2x2 quad
  localparam int NCH = 3;           // components per pixel
  localparam int NTERM = 3;         // product terms per weighted sum
  localparam int SUM_HEAD = 11;     // integer bits above the fraction in a sum
  localparam int CHROMA_BIAS = 128;
  localparam int PIX_MAX = 255;

  typedef enum logic {
    DIR_TO_NV12 = 1'b0,
    DIR_TO_RGB  = 1'b1
  } dir_t;

  typedef struct packed {
    logic valid;
    dir_t mode;
  } stage_ctl_t;

  typedef logic [NPIX-1:0][NCH-1:0][7:0] quad_t;

endpackage

@@ sv/btnv_mult.sv @@
// Stage 1: coefficient products for every pixel and component of a quad.
// Depends on btnv_pkg.
module btnv_mult import btnv_pkg::*; #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  stage_ctl_t                              up,
  output logic                                    up_ready,
  input  quad_t                                   quad,
  output stage_ctl_t                              dn,
  input  logic                                    dn_ready,
  output logic signed [COEF_FRAC_BITS+SUM_HEAD-1:0] term [NPIX][NCH][NTERM]
);

  localparam int SW = COEF_FRAC_BITS + SUM_HEAD;

  // Q-format coefficient magnitudes, round half up.
  localparam logic signed [SW-1:0] C_YR =
    SW'(((64'd2126 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_YG =
    SW'(((64'd7152 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_YB =
    SW'(((64'd722 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_UR =
    SW'(((64'd1146 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_UG =
    SW'(((64'd3854 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_HALF =
    SW'(((64'd5000 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_VG =
    SW'(((64'd4542 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_VB =
    SW'(((64'd458 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_RV =
    SW'(((64'd15748 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_GU =
    SW'(((64'd1873 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_GV =
    SW'(((64'd4681 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [SW-1:0] C_BU =
    SW'(((64'd18556 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);

  function automatic logic signed [SW-1:0] mulc(input logic signed [SW-1:0] c,
                                                 input logic signed [9:0] x);
    logic signed [SW-1:0] xe;
    xe = SW'(x);
    return c * xe;
  endfunction

  logic signed [SW-1:0] term_next [NPIX][NCH][NTERM];
  logic signed [9:0]    cb;
  logic signed [9:0]    cr;

  assign up_ready = !dn.valid || dn_ready;

  always_comb begin
    logic signed [9:0]    sr;
    logic signed [9:0]    sg;
    logic signed [9:0]    sb;
    logic signed [SW-1:0] yq;
    cb = signed'({2'b00, quad[0][1]}) - 10'sd128;
    cr = signed'({2'b00, quad[0][2]}) - 10'sd128;
    for (int k = 0; k < NPIX; k++) begin
      sr = signed'({2'b00, quad[k][0]});
      sg = signed'({2'b00, quad[k][1]});
      sb = signed'({2'b00, quad[k][2]});
      yq = SW'(sr) <<< COEF_FRAC_BITS;
      if (up.mode == DIR_TO_NV12) begin
        term_next[k][0][0] = mulc(C_YR, sr);
        term_next[k][0][1] = mulc(C_YG, sg);
        term_next[k][0][2] = mulc(C_YB, sb);
        term_next[k][1][0] = -mulc(C_UR, sr);
        term_next[k][1][1] = -mulc(C_UG, sg);
        term_next[k][1][2] = mulc(C_HALF, sb);
        term_next[k][2][0] = mulc(C_HALF, sr);
        term_next[k][2][1] = -mulc(C_VG, sg);
        term_next[k][2][2] = -mulc(C_VB, sb);
      end else begin
        // shared chroma, luma moved onto the fraction grid
        term_next[k][0][0] = yq;
        term_next[k][0][1] = mulc(C_RV, cr);
        term_next[k][0][2] = '0;
        term_next[k][1][0] = yq;
        term_next[k][1][1] = -mulc(C_GU, cb);
        term_next[k][1][2] = -mulc(C_GV, cr);
        term_next[k][2][0] = yq;
        term_next[k][2][1] = mulc(C_BU, cb);
        term_next[k][2][2] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn.valid <= 1'b0;
    end else if (up_ready) begin
      dn.valid <= up.valid;
    end
    if (up_ready && up.valid) begin
      dn.mode <= up.mode;
      term    <= term_next;
    end
  end

endmodule

@@ sv/btnv_sum.sv @@
// Stage 2: three-term weighted sums per pixel component.
// Depends on btnv_pkg.
module btnv_sum import btnv_pkg::*; #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  stage_ctl_t                                up,
  output logic                                      up_ready,
  input  logic signed [COEF_FRAC_BITS+SUM_HEAD-1:0] term [NPIX][NCH][NTERM],
  output stage_ctl_t                                dn,
  input  logic                                      dn_ready,
  output logic signed [COEF_FRAC_BITS+SUM_HEAD-1:0] chan [NPIX][NCH]
);

  localparam int SW = COEF_FRAC_BITS + SUM_HEAD;

  logic signed [SW-1:0] chan_next [NPIX][NCH];

  assign up_ready = !dn.valid || dn_ready;

  always_comb begin
    for (int k = 0; k < NPIX; k++) begin
      for (int c = 0; c < NCH; c++) begin
        chan_next[k][c] = term[k][c][0] + term[k][c][1] + term[k][c][2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn.valid <= 1'b0;
    end else if (up_ready) begin
      dn.valid <= up.valid;
    end
    if (up_ready && up.valid) begin
      dn.mode <= up.mode;
      chan    <= chan_next;
    end
  end

endmodule

@@ sv/btnv_sat.sv @@
// Stage 3: drop the fraction toward zero, add chroma offset, clamp to 8 bits.
// Depends on btnv_pkg.
module btnv_sat import btnv_pkg::*; #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  stage_ctl_t                                up,
  output logic                                      up_ready,
  input  logic signed [COEF_FRAC_BITS+SUM_HEAD-1:0] chan [NPIX][NCH],
  output stage_ctl_t                                dn,
  input  logic                                      dn_ready,
  output logic [7:0]                                val [NPIX][NCH]
);

  localparam int SW = COEF_FRAC_BITS + SUM_HEAD;

  function automatic logic [7:0] trunc_sat(input logic signed [SW-1:0] s,
                                           input logic bias);
    logic                 neg;
    logic signed [SW-1:0] mag;
    logic signed [SW-1:0] q;
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] v;
    neg = s[SW-1];
    mag = neg ? -s : s;
    q   = mag >>> COEF_FRAC_BITS;
    t   = neg ? -q : q;
    v   = bias ? t + SW'(CHROMA_BIAS) : t;
    if (v < 0) begin
      return 8'd0;
    end else if (v > SW'(PIX_MAX)) begin
      return 8'(PIX_MAX);
    end else begin
      return v[7:0];
    end
  endfunction

  logic [7:0] val_next [NPIX][NCH];

  assign up_ready = !dn.valid || dn_ready;

  always_comb begin
    for (int k = 0; k < NPIX; k++) begin
      for (int c = 0; c < NCH; c++) begin
        // chroma components carry the offset only when producing NV12
        val_next[k][c] = trunc_sat(chan[k][c], (up.mode == DIR_TO_NV12) && (c != 0));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn.valid <= 1'b0;
    end else if (up_ready) begin
      dn.valid <= up.valid;
    end
    if (up_ready && up.valid) begin
      dn.mode <= up.mode;
      val     <= val_next;
    end
  end

endmodule

@@ sv/bt709_rgb_nv12_quad_convert.sv @@
// BT.709 RGB <-> NV12 converter for one 2x2 quad per item.
// Pipeline stages in order: multiply, sum, truncate/clamp, chroma mean and output register.
// Throughput one quad per clock while out_ready holds; each stage holds one item and stalls only when full.
// Synchronous reset clears all stage valid bits and sets the direction to RGB to NV12.
// Depends on btnv_pkg, btnv_mult, btnv_sum, btnv_sat.
module bt709_rgb_nv12_quad_convert import btnv_pkg::*; #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pix0_c0,
  input  logic [7:0] pix0_c1,
  input  logic [7:0] pix0_c2,
  input  logic [7:0] pix1_c0,
  input  logic [7:0] pix1_c1,
  input  logic [7:0] pix1_c2,
  input  logic [7:0] pix2_c0,
  input  logic [7:0] pix2_c1,
  input  logic [7:0] pix2_c2,
  input  logic [7:0] pix3_c0,
  input  logic [7:0] pix3_c1,
  input  logic [7:0] pix3_c2,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] res0_c0,
  output logic [7:0] res0_c1,
  output logic [7:0] res0_c2,
  output logic [7:0] res1_c0,
  output logic [7:0] res1_c1,
  output logic [7:0] res1_c2,
  output logic [7:0] res2_c0,
  output logic [7:0] res2_c1,
  output logic [7:0] res2_c2,
  output logic [7:0] res3_c0,
  output logic [7:0] res3_c1,
  output logic [7:0] res3_c2
);

  localparam int SW = COEF_FRAC_BITS + SUM_HEAD;

  dir_t       direction;
  stage_ctl_t s0_ctl;
  stage_ctl_t s1_ctl;
  stage_ctl_t s2_ctl;
  stage_ctl_t s3_ctl;
  logic       s1_ready;
  logic       s2_ready;
  logic       s3_ready;
  logic       out_load;
  dir_t       out_mode;
  quad_t      quad;

  logic signed [SW-1:0] term [NPIX][NCH][NTERM];
  logic signed [SW-1:0] chan [NPIX][NCH];
  logic [7:0]           val  [NPIX][NCH];
  logic [7:0]           res      [NPIX][NCH];
  logic [7:0]           res_next [NPIX][NCH];

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_TO_NV12;
    end else if (cfg_wr_en) begin
      direction <= dir_t'(cfg_wr_data);
    end
  end

  assign quad = {pix3_c2, pix3_c1, pix3_c0, pix2_c2, pix2_c1, pix2_c0,
                 pix1_c2, pix1_c1, pix1_c0, pix0_c2, pix0_c1, pix0_c0};

  assign s0_ctl = '{valid: in_valid, mode: direction};

  btnv_mult #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mult (
    .clk      (clk),
    .rst      (rst),
    .up       (s0_ctl),
    .up_ready (in_ready),
    .quad     (quad),
    .dn       (s1_ctl),
    .dn_ready (s1_ready),
    .term     (term)
  );

  btnv_sum #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sum (
    .clk      (clk),
    .rst      (rst),
    .up       (s1_ctl),
    .up_ready (s1_ready),
    .term     (term),
    .dn       (s2_ctl),
    .dn_ready (s2_ready),
    .chan     (chan)
  );

  btnv_sat #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sat (
    .clk      (clk),
    .rst      (rst),
    .up       (s2_ctl),
    .up_ready (s2_ready),
    .chan     (chan),
    .dn       (s3_ctl),
    .dn_ready (s3_ready),
    .val      (val)
  );

  assign s3_ready = !out_valid || out_ready;
  assign out_load = s3_ready && s3_ctl.valid;

  always_comb begin
    logic [9:0] cb_sum;
    logic [9:0] cr_sum;
    cb_sum = '0;
    cr_sum = '0;
    for (int k = 0; k < NPIX; k++) begin
      cb_sum = cb_sum + 10'(val[k][1]);
      cr_sum = cr_sum + 10'(val[k][2]);
    end
    res_next = val;
    if (s3_ctl.mode == DIR_TO_NV12) begin
      // one chroma pair per quad, floor of the mean
      for (int k = 1; k < NPIX; k++) begin
        res_next[k][1] = '0;
        res_next[k][2] = '0;
      end
      res_next[0][1] = cb_sum[9:2];
      res_next[0][2] = cr_sum[9:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s3_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mode <= s3_ctl.mode;
      res      <= res_next;
    end
  end

  assign res0_c0 = res[0][0];
  assign res0_c1 = res[0][1];
  assign res0_c2 = res[0][2];
  assign res1_c0 = res[1][0];
  assign res1_c1 = res[1][1];
  assign res1_c2 = res[1][2];
  assign res2_c0 = res[2][0];
  assign res2_c1 = res[2][1];
  assign res2_c2 = res[2][2];
  assign res3_c0 = res[3][0];
  assign res3_c1 = res[3][1];
  assign res3_c2 = res[3][2];

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_ctl.valid && s2_ctl.valid && s3_ctl.valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the pipeline is full and stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_ctl.valid |-> in_ready)
    else $error("input stalled with an empty first stage");

  a_nv12_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_mode == DIR_TO_NV12 |->
      res1_c1 == 8'd0 && res1_c2 == 8'd0 && res2_c1 == 8'd0 &&
      res2_c2 == 8'd0 && res3_c1 == 8'd0 && res3_c2 == 8'd0)
    else $error("unused chroma outputs not zero in NV12 mode");
`endif

endmodule

@@ test/bt709_rgb_nv12_quad_convert_check.sv @@
// Scoreboard for the BT.709 RGB / NV12 quad converter: watches the config port and both
// item channels, predicts each converted quad and compares it field by field.
// Depends on btnv_pkg.
module bt709_rgb_nv12_quad_convert_check import btnv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_wr_en,
  input  logic  cfg_wr_data,
  input  logic  in_valid,
  input  logic  in_ready,
  input  quad_t in_quad,
  input  logic  out_valid,
  input  logic  out_ready,
  input  quad_t res_quad,
  output int    mismatches,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;

  // Q16 coefficients, magnitude rounded half up
  localparam longint K_Y_R  = (2126 * ONE + 5000) / 10000;
  localparam longint K_Y_G  = (7152 * ONE + 5000) / 10000;
  localparam longint K_Y_B  = (722 * ONE + 5000) / 10000;
  localparam longint K_CB_R = (1146 * ONE + 5000) / 10000;
  localparam longint K_CB_G = (3854 * ONE + 5000) / 10000;
  localparam longint K_HALF = (5000 * ONE + 5000) / 10000;
  localparam longint K_CR_G = (4542 * ONE + 5000) / 10000;
  localparam longint K_CR_B = (458 * ONE + 5000) / 10000;
  localparam longint K_R_V  = (15748 * ONE + 5000) / 10000;
  localparam longint K_G_U  = (1873 * ONE + 5000) / 10000;
  localparam longint K_G_V  = (4681 * ONE + 5000) / 10000;
  localparam longint K_B_U  = (18556 * ONE + 5000) / 10000;

  dir_t  direction;
  quad_t expected_quads[$];
  int    reported;

  function automatic logic [7:0] clamp8(longint v);
    if (v < 0) return 8'd0;
    if (v > PIX_MAX) return 8'(PIX_MAX);
    return 8'(v);
  endfunction

  // signed division drops the fraction toward zero
  function automatic longint drop_frac(longint s);
    return s / ONE;
  endfunction

  function automatic quad_t convert_quad(dir_t dir, quad_t px);
    quad_t  q;
    longint r, g, b, ys, us, vs, yq, u, v;
    int     cb_sum, cr_sum, k;
    q = '0;
    cb_sum = 0;
    cr_sum = 0;
    if (dir == DIR_TO_NV12) begin
      for (k = 0; k < NPIX; k++) begin
        r = longint'(px[k][0]);
        g = longint'(px[k][1]);
        b = longint'(px[k][2]);
        ys = K_Y_R * r + K_Y_G * g + K_Y_B * b;
        us = -K_CB_R * r - K_CB_G * g + K_HALF * b;
        vs = K_HALF * r - K_CR_G * g - K_CR_B * b;
        q[k][0] = clamp8(drop_frac(ys));
        cb_sum += clamp8(drop_frac(us) + CHROMA_BIAS);
        cr_sum += clamp8(drop_frac(vs) + CHROMA_BIAS);
      end
      // floor mean of the four chroma samples
      q[0][1] = 8'(cb_sum >> 2);
      q[0][2] = 8'(cr_sum >> 2);
    end else begin
      u = longint'(px[0][1]) - CHROMA_BIAS;
      v = longint'(px[0][2]) - CHROMA_BIAS;
      for (k = 0; k < NPIX; k++) begin
        yq = longint'(px[k][0]) * ONE;
        q[k][0] = clamp8(drop_frac(yq + K_R_V * v));
        q[k][1] = clamp8(drop_frac(yq - K_G_U * u - K_G_V * v));
        q[k][2] = clamp8(drop_frac(yq + K_B_U * u));
      end
    end
    return q;
  endfunction

  always @(posedge clk) begin
    quad_t want;
    int    bad, k, c;
    if (rst) begin
      direction <= DIR_TO_NV12;
      expected_quads.delete();
      outstanding <= 0;
      mismatches <= 0;
      reported = 0;
    end else begin
      bad = 0;
      if (cfg_wr_en) direction <= dir_t'(cfg_wr_data);
      if (in_valid && in_ready) expected_quads.push_back(convert_quad(direction, in_quad));
      if (out_valid && out_ready) begin
        if (expected_quads.size() == 0) begin
          bad = 1;
          if (reported < 10)
            $display("%0t: unexpected result item %h", $realtime, res_quad);
          reported++;
        end else begin
          want = expected_quads.pop_front();
          for (k = 0; k < NPIX; k++) begin
            for (c = 0; c < NCH; c++) begin
              if (res_quad[k][c] !== want[k][c]) begin
                bad++;
                if (reported < 10)
                  $display("%0t: res%0d_c%0d expected %0d, got %0d", $realtime, k, c,
                           want[k][c], res_quad[k][c]);
                reported++;
              end
            end
          end
        end
      end
      mismatches <= mismatches + bad;
      outstanding <= expected_quads.size();
    end
  end

endmodule

@@ test/tb_bt709_rgb_nv12_quad_convert.sv @@
// Top of the quad converter testbench: clock, reset, direction writes, quad stimulus
// and result back-pressure. Checking lives in bt709_rgb_nv12_quad_convert_check.
// Depends on btnv_pkg and the converter RTL.
module tb_bt709_rgb_nv12_quad_convert import btnv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic  clk;
  logic  rst;
  logic  cfg_wr_en;
  logic  cfg_wr_data;
  logic  in_valid;
  logic  in_ready;
  logic  out_valid;
  logic  out_ready;
  quad_t in_quad;
  wire [NPIX-1:0][NCH-1:0][7:0] res_quad;
  int    mismatches;
  int    outstanding;
  int    hold_requests = 0;
  int    holds_done;

  bt709_rgb_nv12_quad_convert dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pix0_c0     (in_quad[0][0]),
    .pix0_c1     (in_quad[0][1]),
    .pix0_c2     (in_quad[0][2]),
    .pix1_c0     (in_quad[1][0]),
    .pix1_c1     (in_quad[1][1]),
    .pix1_c2     (in_quad[1][2]),
    .pix2_c0     (in_quad[2][0]),
    .pix2_c1     (in_quad[2][1]),
    .pix2_c2     (in_quad[2][2]),
    .pix3_c0     (in_quad[3][0]),
    .pix3_c1     (in_quad[3][1]),
    .pix3_c2     (in_quad[3][2]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res0_c0     (res_quad[0][0]),
    .res0_c1     (res_quad[0][1]),
    .res0_c2     (res_quad[0][2]),
    .res1_c0     (res_quad[1][0]),
    .res1_c1     (res_quad[1][1]),
    .res1_c2     (res_quad[1][2]),
    .res2_c0     (res_quad[2][0]),
    .res2_c1     (res_quad[2][1]),
    .res2_c2     (res_quad[2][2]),
    .res3_c0     (res_quad[3][0]),
    .res3_c1     (res_quad[3][1]),
    .res3_c2     (res_quad[3][2])
  );

  bt709_rgb_nv12_quad_convert_check quad_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_quad     (in_quad),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res_quad    (res_quad),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stall patterns, plus a long hold-off whenever one is requested.
  initial begin
    int mode, len;
    out_ready = 1'b0;
    holds_done = 0;
    forever begin
      if (hold_requests != holds_done) begin
        out_ready <= 1'b0;
        holds_done++;
        repeat (400) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(8, 60);
        repeat (len) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic quad_t flat_quad(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    quad_t q;
    for (int k = 0; k < NPIX; k++) q[k] = {c2, c1, c0};
    return q;
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 3));
      3: return 8'($urandom_range(252, 255));
      4: return 8'($urandom_range(120, 136));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic quad_t random_quad();
    quad_t q;
    for (int k = 0; k < NPIX; k++)
      for (int c = 0; c < NCH; c++) q[k][c] = random_level();
    return q;
  endfunction

  // Raise valid with the item and hold it until accepted; valid stays high on return.
  task automatic push_quad(input quad_t q);
    in_valid <= 1'b1;
    in_quad <= q;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    pause_input(1);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_direction(input dir_t d);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_stream(input int count);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < count; i++) begin
        push_quad(random_quad());
        sent++;
      end
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        2: gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      pause_input(gap);
    end
  endtask

  initial begin
    quad_t q;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    in_quad = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // RGB to NV12 from the reset direction: extremes, primaries, tiny negative sums
    push_quad(flat_quad(8'd0, 8'd0, 8'd0));
    push_quad(flat_quad(8'd255, 8'd255, 8'd255));
    push_quad(flat_quad(8'd255, 8'd0, 8'd0));
    push_quad(flat_quad(8'd0, 8'd255, 8'd0));
    push_quad(flat_quad(8'd0, 8'd0, 8'd255));
    push_quad(flat_quad(8'd1, 8'd0, 8'd0));
    push_quad(flat_quad(8'd0, 8'd1, 8'd1));
    push_quad({NPIX * NCH{8'hAA}});
    push_quad({NPIX * NCH{8'h55}});
    q = flat_quad(8'd255, 8'd0, 8'd0);
    q[1] = {8'd255, 8'd255, 8'd255};
    q[2] = {8'd255, 8'd0, 8'd0};
    q[3] = {8'd0, 8'd255, 8'd0};
    push_quad(q);

    // NV12 to RGB: saturation both ways, neutral chroma, ignored fields toggled
    set_direction(DIR_TO_RGB);
    push_quad(flat_quad(8'd0, 8'd0, 8'd0));
    push_quad(flat_quad(8'd255, 8'd255, 8'd255));
    push_quad(flat_quad(8'd128, 8'd128, 8'd128));
    push_quad(flat_quad(8'd0, 8'd128, 8'd128));
    push_quad(flat_quad(8'd255, 8'd128, 8'd128));
    push_quad(flat_quad(8'd16, 8'd255, 8'd0));
    push_quad(flat_quad(8'd235, 8'd0, 8'd255));
    push_quad({NPIX * NCH{8'hAA}});
    push_quad({NPIX * NCH{8'h55}});
    q = {NPIX * NCH{8'hFF}};
    q[0] = {8'd128, 8'd128, 8'd0};
    q[1][0] = 8'd85;
    q[2][0] = 8'd170;
    q[3][0] = 8'd255;
    push_quad(q);

    for (int p = 0; p < 8; p++) begin
      // the write at p == 5 repeats the previous direction
      set_direction(dir_t'((p == 5) ? 0 : p % 2));
      if (p == 2 || p == 7) begin
        // stall the result side long enough for the pipe to back up into the input
        hold_requests <= hold_requests + 1;
        repeat (60) push_quad(random_quad());
      end
      send_stream(150);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
